>>> rtl/core/qppg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppg_pkg
// Shared types, constants and helpers of the quadrature pulse pattern
// generator: register indexes, queue geometry and the queue entry format.
// ----------------------------------------------------------------------------
package qppg_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int HOLD_W     = 24;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int STRETCH_W  = 9;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 32;

  // Defaults for the top-level parameters.
  localparam int LINE_BITS_DEF = 16;
  localparam int HOLD_BITS_DEF = 24;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] PPR_RESET = 16'd10000;

  // Queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSES_PER_REV   = 2'd0,
    CFG_MARK_STRETCH     = 2'd1,
    CFG_ERROR_ON_REVERSE = 2'd2,
    CFG_START_LINE       = 2'd3
  } qppg_cfg_idx_t;

  // One configuration write.
  typedef struct packed {
    logic                  we;
    qppg_cfg_idx_t         index;
    logic [CFG_DATA_W-1:0] data;
  } qppg_cfg_wr_t;

  // One classified pulse, as it waits in the queue.
  typedef struct packed {
    logic              phase_a;
    logic              phase_b;
    logic              index_mark;
    logic              error_mark;
    logic [HOLD_W-1:0] hold_out;
  } qppg_entry_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               push;
    logic               pop;
  } qppg_fifo_stat_t;

  // A/B levels for a phase: forward runs A, AB, B, none and reverse
  // runs B, AB, A, none. Bit 0 is A, bit 1 is B.
  function automatic logic [1:0] qppg_pattern(input logic fwd, input logic [1:0] phase);
    logic early;
    logic mid;
    begin
      early = (phase == 2'd0) || (phase == 2'd1);
      mid   = (phase == 2'd1) || (phase == 2'd2);
      qppg_pattern = fwd ? {mid, early} : {early, mid};
    end
  endfunction

endpackage

>>> rtl/core/qppg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppg_front
// Front part: holds the configuration registers and the pulse state, accepts
// one pulse per cycle while the queue has room, classified into a queue entry.
// ----------------------------------------------------------------------------
module qppg_front #(
  parameter int LINE_BITS = qppg_pkg::LINE_BITS_DEF,
  parameter int HOLD_BITS = qppg_pkg::HOLD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qppg_pkg::qppg_cfg_wr_t         cfg,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [qppg_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tlast,
  output logic                           push,
  output qppg_pkg::qppg_entry_t          entry,
  input  logic                           q_ready
);
  import qppg_pkg::*;

  // Compare width covers the incremented line count and the period register.
  localparam int CMP_W   = (LINE_BITS + 1 > CFG_DATA_W) ? LINE_BITS + 1 : CFG_DATA_W;
  localparam int HOLD_KW = (HOLD_BITS < HOLD_W) ? HOLD_BITS : HOLD_W;
  localparam logic [HOLD_W-1:0] HOLD_MASK = {HOLD_W{1'b1}} >> (HOLD_W - HOLD_KW);

  logic [CFG_DATA_W-1:0] pulses_per_rev;
  logic [STRETCH_W-1:0]  mark_stretch;
  logic                  error_on_reverse;
  logic [1:0]            quad_phase;
  logic [LINE_BITS-1:0]  line_count;
  logic [7:0]            stretch_left;

  logic                  fwd;
  logic [HOLD_W-1:0]     hold;
  logic                  take;
  logic [CMP_W-1:0]      line_inc;
  logic [LINE_BITS-1:0]  line_next;
  logic                  at_index;
  logic [7:0]            stretch_mid;
  logic [7:0]            stretch_left_next;
  logic [1:0]            ab;

  assign fwd      = s_tdata[0];
  assign hold     = s_tdata[HOLD_W:1];
  assign s_tready = q_ready;
  assign take     = s_tvalid && s_tready;

  // Line step: wrap to zero once the count reaches the period.
  always_comb begin
    line_inc  = CMP_W'(line_count) + CMP_W'(1);
    line_next = line_count + LINE_BITS'(1);
    if (line_inc >= CMP_W'(pulses_per_rev)) begin
      line_next = '0;
    end
  end

  // Index level and stretch countdown.
  always_comb begin
    at_index    = (line_next == '0) && !mark_stretch[STRETCH_W-1];
    stretch_mid = stretch_left;
    if (at_index && (mark_stretch[7:0] != 8'd0)) begin
      stretch_mid = mark_stretch[7:0];
    end
    stretch_left_next = (stretch_mid != 8'd0) ? stretch_mid - 8'd1 : 8'd0;
    if (s_tlast) begin
      stretch_left_next = 8'd0;
    end
  end

  // Classified entry for the queue.
  assign ab                = qppg_pattern(fwd, quad_phase);
  assign push              = take;
  assign entry.phase_a     = ab[0];
  assign entry.phase_b     = ab[1];
  assign entry.index_mark  = at_index || (stretch_mid != 8'd0);
  assign entry.error_mark  = !fwd && error_on_reverse;
  assign entry.hold_out    = hold & HOLD_MASK;

  // Configuration registers; a start line write also reloads the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_rev   <= PPR_RESET;
      mark_stretch     <= '0;
      error_on_reverse <= 1'b0;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_PULSES_PER_REV:   pulses_per_rev   <= cfg.data;
        CFG_MARK_STRETCH:     mark_stretch     <= cfg.data[STRETCH_W-1:0];
        CFG_ERROR_ON_REVERSE: error_on_reverse <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Pulse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_phase   <= 2'd0;
      line_count   <= '0;
      stretch_left <= 8'd0;
    end else if (cfg.we && (cfg.index == CFG_START_LINE)) begin
      line_count <= LINE_BITS'(cfg.data);
    end else if (take) begin
      quad_phase   <= quad_phase + 2'd1;
      line_count   <= line_next;
      stretch_left <= stretch_left_next;
    end
  end

endmodule

>>> rtl/core/qppg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppg_fifo
// Short queue of classified pulses between the front and back parts.
// ----------------------------------------------------------------------------
module qppg_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  qppg_pkg::qppg_entry_t    wr_entry,
  output logic                     wr_ready,
  input  logic                     pop,
  output logic                     rd_valid,
  output qppg_pkg::qppg_entry_t    rd_entry,
  output qppg_pkg::qppg_fifo_stat_t stat
);
  import qppg_pkg::*;

  qppg_entry_t        slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign wr_ready   = (count != FIFO_CW'(FIFO_DEPTH));
  assign rd_valid   = (count != '0);
  assign rd_entry   = slots[rd_ptr];
  assign do_push    = push && wr_ready;
  assign do_pop     = pop && rd_valid;
  assign stat.count = count;
  assign stat.push  = do_push;
  assign stat.pop   = do_pop;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/qppg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppg_back
// Back part: takes entries from the queue into the output register and
// presents them on the master stream.
// ----------------------------------------------------------------------------
module qppg_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  qppg_pkg::qppg_entry_t          q_entry,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [qppg_pkg::M_TDATA_W-1:0] m_tdata
);
  import qppg_pkg::*;

  qppg_entry_t out_reg;
  logic        load;

  assign load = q_valid && (!m_tvalid || m_tready);
  assign pop  = load;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= q_entry;
    end
  end

  // Pack the result fields from the lowest bit up.
  assign m_tdata = M_TDATA_W'({out_reg.hold_out, out_reg.error_mark, out_reg.index_mark,
                               out_reg.phase_b, out_reg.phase_a});

endmodule

>>> rtl/core/quadrature_pulse_pattern_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_pulse_pattern_generator
// Turns a stream of encoder pulses into quadrature A/B, index and error levels
// with the hold time of each pulse.
// ----------------------------------------------------------------------------
// The block takes one pulse per clock cycle while the queue has room and
// gives one result per pulse, in order. A pulse is classified and written
// into the four-entry queue at its transfer edge and moves on into the
// output register once that register is free; from there it is presented
// on the output stream. The queue lets the input keep going while the
// output is stalled, until five results wait: four in the queue and one in
// the output register.
// Configuration writes are taken at any time, but must only be made while no
// pulse is in flight; a write of the start line reloads the line counter at
// once.
// ----------------------------------------------------------------------------
module quadrature_pulse_pattern_generator #(
  parameter int LINE_BITS = qppg_pkg::LINE_BITS_DEF,
  parameter int HOLD_BITS = qppg_pkg::HOLD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [qppg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qppg_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pulse input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [qppg_pkg::S_TDATA_W-1:0]  s_tdata,  // forwards, hold_ticks[23:0]
  input  logic                            s_tlast,  // burst_last
  // Pattern output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [qppg_pkg::M_TDATA_W-1:0]  m_tdata   // phase_a, phase_b, index_mark,
                                                    // error_mark, hold_out[23:0]
);
  import qppg_pkg::*;

  qppg_cfg_wr_t    cfg;
  logic            push;
  qppg_entry_t     wr_entry;
  logic            q_ready;
  logic            pop;
  logic            q_valid;
  qppg_entry_t     q_entry;
  qppg_fifo_stat_t fifo_stat;

  assign cfg.we    = cfg_we;
  assign cfg.index = qppg_cfg_idx_t'(cfg_index);
  assign cfg.data  = cfg_data;

  // Front part: state and classification.
  qppg_front #(
    .LINE_BITS (LINE_BITS),
    .HOLD_BITS (HOLD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .push     (push),
    .entry    (wr_entry),
    .q_ready  (q_ready)
  );

  // Queue between the parts.
  qppg_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_entry (q_entry),
    .stat     (fifo_stat)
  );

  // Back part: output register.
  qppg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The fill count never goes past the queue depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_stat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue fill count above depth");

  // The fill count follows the transfers in and out of the queue.
  a_fifo_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fifo_stat.count == $past(fifo_stat.count)
      + FIFO_CW'($past(fifo_stat.push)) - FIFO_CW'($past(fifo_stat.pop)))
    else $error("queue fill count lost a transfer");

  // A waiting entry reaches the output register when it is free.
  a_back_fill: assert property (@(posedge clk) disable iff (rst)
    (fifo_stat.count != '0) && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("output register not loaded from a non-empty queue");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench of the quadrature pulse pattern generator. Encoder
// pulses go in on the input stream; a predictor tracks the quadrature phase,
// line counter and index stretch, and every output transfer is compared field
// by field with the oldest predicted pattern. Directed pulses cover reset
// state, both quadrature sequences, index stretch and line wrap, then random
// bursts run under several register settings and idle modes.
// ----------------------------------------------------------------------------
module testbench;
  import qppg_pkg::*;

  localparam int  ITEMS_PER_PHASE = 160;
  localparam int  RANDOM_PHASES   = 12;
  localparam time RUN_LIMIT       = 2_000_000;

  // One predicted output pattern.
  typedef struct packed {
    logic        phase_a;
    logic        phase_b;
    logic        index_mark;
    logic        error_mark;
    logic [23:0] hold_out;
  } pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // forwards, hold_ticks[23:0], zero fill
  logic        s_tlast = 1'b0;  // burst_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // phase_a, phase_b, index_mark, error_mark,
                                // hold_out[23:0], zero fill

  // Register copies and pulse state of the predictor.
  logic [15:0] ppr_reg      = PPR_RESET;
  logic [8:0]  stretch_reg  = '0;
  logic        err_rev_reg  = 1'b0;
  logic [1:0]  quad_ph      = '0;
  logic [15:0] line_pos     = '0;
  logic [7:0]  stretch_left = '0;

  pattern_t pattern_q[$];
  int       mismatches     = 0;
  int       pulses_sent    = 0;
  int       patterns_seen  = 0;
  int       index_seen     = 0;
  int       error_seen     = 0;
  int       settings_used  = 0;
  int       src_idle_pct   = 0;
  int       sink_stall_pct = 0;

  always #5 clk = ~clk;

  quadrature_pulse_pattern_generator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Advance the encoder state by one pulse and return the pattern it gives.
  function automatic pattern_t predict_pattern(input logic fwd, input logic [23:0] hold,
                                               input logic last);
    pattern_t    res;
    logic [16:0] line_next;
    begin
      case (quad_ph)
        2'd0: {res.phase_a, res.phase_b} = fwd ? 2'b10 : 2'b01;
        2'd1: {res.phase_a, res.phase_b} = 2'b11;
        2'd2: {res.phase_a, res.phase_b} = fwd ? 2'b01 : 2'b10;
        default: {res.phase_a, res.phase_b} = 2'b00;
      endcase
      line_next = {1'b0, line_pos} + 17'd1;
      line_pos  = (line_next >= {1'b0, ppr_reg}) ? 16'd0 : line_next[15:0];
      res.index_mark = 1'b0;
      // Line zero raises the index unless the stretch is negative.
      if (line_pos == 16'd0 && !stretch_reg[8]) begin
        res.index_mark = 1'b1;
        if (stretch_reg[7:0] != 8'd0) stretch_left = stretch_reg[7:0];
      end
      if (stretch_left != 8'd0) begin
        res.index_mark = 1'b1;
        stretch_left   = stretch_left - 8'd1;
      end
      res.error_mark = !fwd && err_rev_reg;
      res.hold_out   = hold;
      quad_ph = quad_ph + 2'd1;
      if (last) stretch_left = '0;
      return res;
    end
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Track register writes and input transfers, and check output transfers.
  always @(posedge clk) begin : track_proc
    pattern_t want;
    if (rst) begin
      ppr_reg      = PPR_RESET;
      stretch_reg  = '0;
      err_rev_reg  = 1'b0;
      quad_ph      = '0;
      line_pos     = '0;
      stretch_left = '0;
    end else begin
      if (cfg_we) begin
        case (qppg_cfg_idx_t'(cfg_index))
          CFG_PULSES_PER_REV:   ppr_reg = cfg_data;
          CFG_MARK_STRETCH:     stretch_reg = cfg_data[8:0];
          CFG_ERROR_ON_REVERSE: err_rev_reg = cfg_data[0];
          CFG_START_LINE:       line_pos = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pattern_q.push_back(predict_pattern(s_tdata[0], s_tdata[24:1], s_tlast));
      if (m_tvalid && m_tready) begin
        patterns_seen++;
        index_seen += m_tdata[2];
        error_seen += m_tdata[3];
        if (pattern_q.size() == 0) begin
          $error("Unexpected output transfer 0x%0h", m_tdata);
          mismatches++;
        end else begin
          want = pattern_q.pop_front();
          check_field("phase_a", 24'(want.phase_a), 24'(m_tdata[0]));
          check_field("phase_b", 24'(want.phase_b), 24'(m_tdata[1]));
          check_field("index_mark", 24'(want.index_mark), 24'(m_tdata[2]));
          check_field("error_mark", 24'(want.error_mark), 24'(m_tdata[3]));
          check_field("hold_out", want.hold_out, m_tdata[27:4]);
        end
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Send one pulse; returns at the edge where it is transferred.
  task automatic send_pulse(input logic fwd, input logic [23:0] hold, input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, hold, fwd};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pulses_sent++;
  endtask

  // Hold off the input until every predicted pattern has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pattern_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write, after which the write port is left idle.
  task automatic write_reg(input qppg_cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] ppr, input logic [8:0] stretch,
                            input logic err_rev, input logic [15:0] start);
    write_reg(CFG_PULSES_PER_REV, ppr);
    write_reg(CFG_MARK_STRETCH, {7'd0, stretch});
    write_reg(CFG_ERROR_ON_REVERSE, {15'd0, err_rev});
    write_reg(CFG_START_LINE, start);
    settings_used++;
  endtask

  // A few pulses under the reset settings: far from line zero, no index.
  task automatic test_reset_defaults();
    send_pulse(1'b1, 24'd1, 1'b0);
    send_pulse(1'b1, 24'd2, 1'b0);
    send_pulse(1'b0, 24'd3, 1'b0);
    send_pulse(1'b1, 24'd4, 1'b1);
    drain_results();
  endtask

  // Both sequences through all four phases, with extreme hold values.
  task automatic test_quadrature_sequences();
    set_config(16'd4, 9'd0, 1'b1, 16'd0);
    send_pulse(1'b1, 24'h000000, 1'b0);
    send_pulse(1'b1, 24'hFFFFFF, 1'b0);
    send_pulse(1'b1, 24'hAAAAAA, 1'b0);
    send_pulse(1'b1, 24'h555555, 1'b0);
    send_pulse(1'b0, 24'h000001, 1'b0);
    send_pulse(1'b0, 24'h800000, 1'b0);
    send_pulse(1'b0, 24'h7FFFFF, 1'b0);
    send_pulse(1'b0, 24'hFFFFFE, 1'b1);
    drain_results();
  endtask

  // Index stretch longer than a revolution restarts on line zero, is cut by
  // the end of a burst, and a negative stretch suppresses the index.
  task automatic test_index_stretch();
    set_config(16'd3, 9'd4, 1'b0, 16'd2);
    send_pulse(1'b1, 24'd10, 1'b0);
    send_pulse(1'b1, 24'd11, 1'b0);
    send_pulse(1'b1, 24'd12, 1'b0);
    send_pulse(1'b1, 24'd13, 1'b0);
    send_pulse(1'b0, 24'd14, 1'b1);
    send_pulse(1'b0, 24'd15, 1'b0);
    drain_results();
    write_reg(CFG_MARK_STRETCH, 16'h01FF);
    send_pulse(1'b1, 24'd16, 1'b0);
    drain_results();
  endtask

  // Start line at or above the revolution count, zero and largest counts.
  task automatic test_line_wrap();
    set_config(16'd5, 9'd0, 1'b0, 16'd9);
    send_pulse(1'b1, 24'd20, 1'b0);
    send_pulse(1'b1, 24'd21, 1'b0);
    drain_results();
    set_config(16'd0, 9'd0, 1'b1, 16'hFFFF);
    send_pulse(1'b0, 24'd22, 1'b0);
    send_pulse(1'b0, 24'd23, 1'b1);
    drain_results();
    set_config(16'hFFFF, 9'd255, 1'b0, 16'hFFFE);
    send_pulse(1'b1, 24'd24, 1'b0);
    drain_results();
  endtask

  // Random bursts under changing register settings and idle modes.
  task automatic test_random_bursts();
    int          sent;
    int          burst_len;
    int          ppr;
    int          start;
    logic        dir;
    logic        fwd;
    logic [8:0]  stretch;
    logic [23:0] hold;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(16'd1, 9'd0, 1'b0, 16'd0);
        1: set_config(16'd0, 9'd3, 1'b1, 16'd5);
        2: set_config(16'hFFFF, 9'd255, 1'b1, 16'hFFFA);
        3: set_config(16'd2, 9'h1FF, 1'b0, 16'hFFFF);
        4: set_config(16'd7, 9'h100, 1'b1, 16'd3);
        default: begin
          case ($urandom_range(7))
            0: ppr = $urandom_range(65535);
            1: ppr = 0;
            default: ppr = $urandom_range(1, 24);
          endcase
          case ($urandom_range(5))
            0: stretch = 9'($urandom_range(511));
            1: stretch = 9'h1FF;
            default: stretch = 9'($urandom_range(0, 8));
          endcase
          start = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(0, ppr + 2);
          set_config(16'(ppr), stretch, 1'($urandom_range(1)), 16'(start));
        end
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst_len = $urandom_range(1, 12);
        dir = 1'($urandom_range(1));
        for (int k = 0; k < burst_len; k++) begin
          fwd = ($urandom_range(9) == 0) ? !dir : dir;
          case ($urandom_range(9))
            0: hold = 24'd0;
            1: hold = 24'd1;
            2: hold = 24'hFFFFFF;
            3: hold = 24'($urandom_range(1, 16));
            default: hold = 24'($urandom());
          endcase
          send_pulse(fwd, hold, (k == burst_len - 1) || ($urandom_range(19) == 0));
          sent++;
          // Pause mid-phase until the output has caught up.
          if (sent == ITEMS_PER_PHASE / 2) drain_results();
        end
      end
      drain_results();
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_quadrature_sequences();
    test_index_stretch();
    test_line_wrap();
    test_random_bursts();
    drain_results();
    $display("Sent %0d pulses under %0d register settings; %0d patterns checked.",
             pulses_sent, settings_used, patterns_seen);
    $display("Saw %0d index and %0d error marks across all four idle modes.",
             index_seen, error_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule
